// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

  // Decoded length is kept to this many bits; wider lengths lose their high bits.
  localparam int LENGTH_BITS = 64;
  localparam int SIZE_W      = 64;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Index of the last byte of each multi-byte header field.
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  typedef struct packed {
    logic              kind;
    logic              final_fragment;
    logic [3:0]        frame_opcode;
    logic              is_masked;
    logic [SIZE_W-1:0] payload_size;
    logic [7:0]        data_out;
    logic              last;
  } wsd_result_t;

endpackage

// ===== hdl/wsd_in_if.sv =====
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== hdl/wsd_out_if.sv =====
interface wsd_out_if
  import wsd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              final_fragment;
  logic [3:0]        frame_opcode;
  logic              is_masked;
  logic [SIZE_W-1:0] payload_size;
  logic [7:0]        data_out;
  logic              last;

  modport source (output valid, output kind, output final_fragment, output frame_opcode,
                  output is_masked, output payload_size, output data_out, output last,
                  input ready);
  modport sink (input valid, input kind, input final_fragment, input frame_opcode,
                input is_masked, input payload_size, input data_out, input last,
                output ready);
endinterface

// ===== hdl/wsd_parser.sv =====
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  stream_byte,
  output logic        res_valid,
  output wsd_result_t res
);

  localparam int LEN_W = LENGTH_BITS;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SECOND = 3'd1,
    PH_EXT16  = 3'd2,
    PH_EXT64  = 3'd3,
    PH_KEY    = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  phase_t           phase, phase_next;
  logic             fin_flag, fin_next;
  logic [3:0]       opcode_hold, opcode_next;
  logic             mask_flag, mask_next;
  logic [LEN_W-1:0] length_accum, accum_next;
  logic [LEN_W-1:0] bytes_remaining, remain_next;
  logic [2:0]       hdr_count, count_next;
  logic [31:0]      mask_key, key_next;
  logic [1:0]       key_index, index_next;
  logic             len_done;
  logic             emit_hdr;
  logic [7:0]       key_byte;
  logic             last_byte;

  always_comb begin
    phase_next  = phase;
    fin_next    = fin_flag;
    opcode_next = opcode_hold;
    mask_next   = mask_flag;
    accum_next  = length_accum;
    remain_next = bytes_remaining;
    count_next  = hdr_count;
    key_next    = mask_key;
    index_next  = key_index;
    len_done    = 1'b0;
    emit_hdr    = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    if (!mask_flag) key_byte = 8'h00;
    last_byte = (bytes_remaining[LEN_W-1:1] == '0);

    if (step) begin
      unique case (phase)
        PH_SECOND: begin
          mask_next  = stream_byte[7];
          count_next = 3'd0;
          accum_next = '0;
          if (stream_byte[6:0] == LEN7_EXT16) begin
            phase_next = PH_EXT16;
          end else if (stream_byte[6:0] == LEN7_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            accum_next = LEN_W'(stream_byte[6:0]);
            len_done   = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          accum_next = {length_accum[LEN_W-9:0], stream_byte};
          if (hdr_count >= ((phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
            len_done = 1'b1;
          end else begin
            count_next = hdr_count + 3'd1;
          end
        end
        PH_KEY: begin
          key_next = {mask_key[23:0], stream_byte};
          if (hdr_count >= KEY_LAST) begin
            emit_hdr = 1'b1;
          end else begin
            count_next = hdr_count + 3'd1;
          end
        end
        PH_DATA: begin
          res_valid          = 1'b1;
          res.kind           = KIND_DATA;
          res.final_fragment = fin_flag;
          res.frame_opcode   = opcode_hold;
          res.is_masked      = mask_flag;
          res.data_out       = stream_byte ^ key_byte;
          res.last           = last_byte;
          index_next         = key_index + 2'd1;
          if (last_byte) begin
            remain_next = '0;
            phase_next  = PH_FIRST;
          end else begin
            remain_next = bytes_remaining - LEN_W'(1);
          end
        end
        default: begin
          fin_next    = stream_byte[7];
          opcode_next = stream_byte[3:0];
          phase_next  = PH_SECOND;
        end
      endcase

      // length known: masked frames still need the 4 key bytes
      if (len_done) begin
        if (mask_next) begin
          phase_next = PH_KEY;
          count_next = 3'd0;
          key_next   = '0;
        end else begin
          emit_hdr = 1'b1;
        end
      end

      if (emit_hdr) begin
        res_valid          = 1'b1;
        res.kind           = KIND_HEADER;
        res.final_fragment = fin_next;
        res.frame_opcode   = opcode_next;
        res.is_masked      = mask_next;
        res.payload_size   = SIZE_W'(accum_next);
        res.last           = (accum_next == '0);
        count_next         = 3'd0;
        index_next         = 2'd0;
        remain_next        = accum_next;
        phase_next         = (accum_next == '0) ? PH_FIRST : PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      fin_flag        <= 1'b0;
      opcode_hold     <= '0;
      mask_flag       <= 1'b0;
      length_accum    <= '0;
      bytes_remaining <= '0;
      hdr_count       <= '0;
      mask_key        <= '0;
      key_index       <= '0;
    end else begin
      phase           <= phase_next;
      fin_flag        <= fin_next;
      opcode_hold     <= opcode_next;
      mask_flag       <= mask_next;
      length_accum    <= accum_next;
      bytes_remaining <= remain_next;
      hdr_count       <= count_next;
      mask_key        <= key_next;
      key_index       <= index_next;
    end
  end

endmodule

// ===== hdl/wsd_out_reg.sv =====
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  wsd_result_t res,
  output logic        free,
  wsd_out_if.source   tx
);

  logic        valid;
  wsd_result_t res_q;

  assign free = !valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_q <= res;
    end
  end

  assign tx.valid          = valid;
  assign tx.kind           = res_q.kind;
  assign tx.final_fragment = res_q.final_fragment;
  assign tx.frame_opcode   = res_q.frame_opcode;
  assign tx.is_masked      = res_q.is_masked;
  assign tx.payload_size   = res_q.payload_size;
  assign tx.data_out       = res_q.data_out;
  assign tx.last           = res_q.last;

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket frame deframer.
// rx carries the raw frame stream, one byte per beat. tx carries results:
// one header beat (kind 0) when a frame header is complete, then one beat
// per payload byte (kind 1) with the masking key removed; last marks the
// final payload byte, or the header beat of a frame with no payload.
// Header bytes before the last one produce no beat.
// Path: a byte taken from rx sits in the input register, is parsed and
// lands in the output register; tx.valid is high after it.
// Throughput: one byte per cycle while tx does not stall, set by the single
// parse stage between the input register and the output register.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the first header byte with all fields cleared.
// When tx stalls, the output register holds its beat, the input register
// holds one more byte, and rx.ready drops until tx drains.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  wsd_in_if.sink    rx,
  wsd_out_if.source tx
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_free;
  logic        advance;
  logic        res_valid;
  wsd_result_t res;

  assign advance  = s1_valid && out_free;
  assign rx.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.stream_byte;
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .stream_byte (s1_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (advance && res_valid),
    .res  (res),
    .free (out_free),
    .tx   (tx)
  );

`ifndef SYNTHESIS
  // a stalled byte in the input register must not change or vanish
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_byte))
    else $error("input register lost a stalled byte");

  a_hdr_last: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.kind == KIND_HEADER |-> tx.last == (tx.payload_size == '0))
    else $error("header last flag disagrees with payload size");

  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.kind == KIND_DATA |-> tx.payload_size == '0)
    else $error("payload beat carries a nonzero size");

  a_hdr_data_zero: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.kind == KIND_HEADER |-> tx.data_out == 8'h00)
    else $error("header beat carries data");
`endif

endmodule
